>>> src/buffer_pool_frame_replacer_defines.svh
// Assertion macros shared by the buffer pool frame replacer.
`ifndef BUFFER_POOL_FRAME_REPLACER_DEFINES_SVH
`define BUFFER_POOL_FRAME_REPLACER_DEFINES_SVH
// Asserts that a condition implies a consequence in the same cycle.
`define BPFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Asserts that a condition implies a consequence in the next cycle.
`define BPFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> src/bpfr_pkg.sv
// Package with types and constants of the buffer pool frame replacer.
package bpfr_pkg;
  localparam int NumFrames = 16;
  localparam int PageBits  = 24;
  localparam int SlotW     = $clog2(NumFrames);
  localparam int OccW      = $clog2(NumFrames + 1);

  localparam logic [2:0] KindPin   = 3'd0;
  localparam logic [2:0] KindUnpin = 3'd1;
  localparam logic [2:0] KindDirty = 3'd2;
  localparam logic [2:0] KindForce = 3'd3;
  localparam logic [2:0] KindFlush = 3'd4;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StAbsent   = 2'd1;
  localparam logic [1:0] StNoSpace  = 2'd2;
  localparam logic [1:0] StPinned   = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [23:0] page_num;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  frame_slot;
    logic        load_request;
    logic        write_back;
    logic [23:0] write_page;
    logic [15:0] pin_count;
    logic        last;
    logic [31:0] read_count;
    logic [31:0] write_count;
  } res_t;

  // One frame's metadata word as stored in the memory.
  typedef struct packed {
    logic [PageBits-1:0] page;
    logic [15:0]         pins;
    logic                dirty;
    logic [SlotW-1:0]    rank;
  } meta_t;
endpackage

>>> src/bpfr_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
interface bpfr_req_if import bpfr_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpfr_res_if import bpfr_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpfr_cfg_if ();
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/bpfr_meta_ram.sv
// Frame metadata memory with one write and one registered read port.
module bpfr_meta_ram import bpfr_pkg::*; (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [SlotW-1:0] waddr_i,
  input  meta_t            wdata_i,
  input  logic [SlotW-1:0] raddr_i,
  output meta_t            rdata_o
);
  meta_t mem [NumFrames];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

>>> src/buffer_pool_frame_replacer.sv
// Top level of the buffer pool frame replacer.
// Usage: requests arrive as beats on req (kind, page_num); each accepted
// request of a defined kind yields one or more res beats, the final one
// with last set. A one-bit configuration channel selects FIFO (0) or LRU (1)
// eviction and should be written only while the block is idle.
// Frame metadata (tag, pins, dirty, rank) lives in a synchronous memory
// with one read and one write port; valid bits sit in flip-flops so that
// reset empties the pool at once, without a clearing pass.
// Sequence: a pin, unpin, dirty or force request first scans all frames,
// one memory read a cycle, then passes the decision state; the result beat
// follows, after a write state when the frame entry is written back. A pin
// that moves a frame to newest adds a rank pass. A flush makes a counting
// pass and then one pass over all frames per rank up to the newest dirty,
// unpinned frame, with a result beat for each frame that it writes back.
// One request is worked on at a time; the next is taken the cycle after
// its last result beat leaves.
// Stalls: a result waits in the output register until res.ready; the
// block does not advance while a result is waiting.
// Reset clears valid bits, occupancy, counters, policy and the sequencer.
module buffer_pool_frame_replacer import bpfr_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  bpfr_req_if.sink   req,
  bpfr_res_if.source res,
  bpfr_cfg_if.sink   cfg
);
  `include "buffer_pool_frame_replacer_defines.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_RD, S_WR, S_SHIFT, S_FLUSH, S_FLWR, S_OUT
  } state_e;

  state_e state_q;
  req_t   req_q;
  logic   policy_q;
  logic [NumFrames-1:0] valid_q;
  logic [OccW-1:0]  occ_q;
  logic [31:0]      loads_q, writes_q;

  // Scan control.
  logic [SlotW:0]   idx_q;       // one wider: holds the count itself
  logic             pipe_v_q;    // read data this cycle belongs to pipe_a_q
  logic [SlotW-1:0] pipe_a_q;
  logic             hit_q, free_q, vict_q;
  logic [SlotW-1:0] hit_s_q, free_s_q, vict_s_q;
  meta_t            hit_m_q, vict_m_q;
  logic [SlotW-1:0] tgt_q;       // frame acted on
  logic [SlotW-1:0] old_rank_q;
  logic [SlotW-1:0] flrank_q;    // rank scanned by flush
  logic             flfound_q;
  logic [SlotW:0]   fltotal_q, flcnt_q;
  logic             flpre_q;     // first flush pass counts candidates
  meta_t            wmeta_q;
  res_t             res_q;
  logic             res_v_q;
  logic             after_out_q; // return to flush after the result

  // Memory.
  logic             we;
  logic [SlotW-1:0] waddr, raddr;
  meta_t            wdata, rdata;

  bpfr_meta_ram u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign req.ready = (state_q == S_IDLE) && !res_v_q;
  assign cfg.ready = 1'b1;
  assign res.valid = res_v_q;
  assign res.data  = res_q;

  logic [PageBits-1:0] pg;
  assign pg = req_q.page_num[PageBits-1:0];
  logic scan_go;
  assign scan_go = !idx_q[SlotW];
  logic [SlotW-1:0] idx_lo;
  assign idx_lo = idx_q[SlotW-1:0];
  logic pv;
  assign pv = pipe_v_q && valid_q[pipe_a_q];

  // Memory port steering.
  always_comb begin
    raddr = idx_lo;
    we    = 1'b0;
    waddr = tgt_q;
    wdata = wmeta_q;
    if (state_q == S_WR || state_q == S_FLWR) begin
      we = 1'b1;
    end else if (state_q == S_SHIFT && pv && rdata.rank > old_rank_q) begin
      we    = 1'b1;
      waddr = pipe_a_q;
      wdata = rdata;
      wdata.rank = rdata.rank - 1'b1;
    end
  end

  function automatic res_t mk(input logic [1:0] st, input logic [SlotW-1:0] s,
                              input logic ld, input logic wb,
                              input logic [PageBits-1:0] wp,
                              input logic [15:0] pc, input logic lst,
                              input logic [31:0] rc, input logic [31:0] wc);
    res_t r;
    r.status       = st;
    r.frame_slot   = 4'(s);
    r.load_request = ld;
    r.write_back   = wb;
    r.write_page   = 24'(wp);
    r.pin_count    = pc;
    r.last         = lst;
    r.read_count   = rc;
    r.write_count  = wc;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      policy_q <= 1'b0;
      valid_q <= '0;
      occ_q <= '0;
      loads_q <= '0;
      writes_q <= '0;
      res_v_q <= 1'b0;
      pipe_v_q <= 1'b0;
      idx_q <= '0;
      after_out_q <= 1'b0;
    end else begin
      if (cfg.valid) policy_q <= cfg.data;
      if (res_v_q && res.ready) res_v_q <= 1'b0;
      pipe_v_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            req_q  <= req.data;
            idx_q  <= '0;
            hit_q  <= 1'b0;
            free_q <= 1'b0;
            vict_q <= 1'b0;
            flrank_q <= '0;
            flcnt_q <= '0;
            fltotal_q <= '0;
            flfound_q <= 1'b0;
            flpre_q <= 1'b1;
            if (req.data.kind == KindFlush) state_q <= S_FLUSH;
            else if (req.data.kind inside {[KindPin:KindForce]}) state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_go) begin
            pipe_v_q <= 1'b1;
            pipe_a_q <= idx_lo;
            idx_q <= idx_q + 1'b1;
          end
          if (pipe_v_q) begin
            if (pv && rdata.page == pg && !hit_q) begin
              hit_q <= 1'b1;
              hit_s_q <= pipe_a_q;
              hit_m_q <= rdata;
            end
            if (!valid_q[pipe_a_q] && !free_q) begin
              free_q <= 1'b1;
              free_s_q <= pipe_a_q;
            end
            if (pv && rdata.pins == 16'd0 &&
                (!vict_q || rdata.rank < vict_m_q.rank)) begin
              vict_q <= 1'b1;
              vict_s_q <= pipe_a_q;
              vict_m_q <= rdata;
            end
          end else if (!scan_go) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          state_q <= S_OUT;
          after_out_q <= 1'b0;
          res_v_q <= 1'b1;
          if (req_q.kind == KindPin) begin
            if (hit_q) begin
              wmeta_q <= hit_m_q;
              if (hit_m_q.pins != 16'hFFFF) wmeta_q.pins <= hit_m_q.pins + 1'b1;
              tgt_q <= hit_s_q;
              old_rank_q <= hit_m_q.rank;
              if (policy_q) wmeta_q.rank <= SlotW'(occ_q - 1'b1);
              res_q <= mk(StOk, hit_s_q, 1'b0, 1'b0, '0,
                          (hit_m_q.pins != 16'hFFFF) ? hit_m_q.pins + 1'b1 : hit_m_q.pins,
                          1'b1, loads_q, writes_q);
              res_v_q <= 1'b0;
              state_q <= S_WR;
            end else if (free_q) begin
              wmeta_q <= '{page: pg, pins: 16'd1, dirty: 1'b0, rank: SlotW'(occ_q)};
              tgt_q <= free_s_q;
              valid_q[free_s_q] <= 1'b1;
              occ_q <= occ_q + 1'b1;
              loads_q <= loads_q + 1'b1;
              res_q <= mk(StOk, free_s_q, 1'b1, 1'b0, '0, 16'd1, 1'b1,
                          loads_q + 1'b1, writes_q);
              res_v_q <= 1'b0;
              old_rank_q <= '1;
              state_q <= S_WR;
            end else if (vict_q) begin
              wmeta_q <= '{page: pg, pins: 16'd1, dirty: 1'b0,
                           rank: SlotW'(occ_q - 1'b1)};
              tgt_q <= vict_s_q;
              old_rank_q <= vict_m_q.rank;
              loads_q <= loads_q + 1'b1;
              if (vict_m_q.dirty) writes_q <= writes_q + 1'b1;
              res_q <= mk(StOk, vict_s_q, 1'b1, vict_m_q.dirty,
                          vict_m_q.dirty ? vict_m_q.page : '0, 16'd1, 1'b1,
                          loads_q + 1'b1, writes_q + 32'(vict_m_q.dirty));
              res_v_q <= 1'b0;
              state_q <= S_WR;
            end else begin
              res_q <= mk(StNoSpace, '0, 1'b0, 1'b0, '0, 16'd0, 1'b1,
                          loads_q, writes_q);
            end
          end else if (!hit_q) begin
            res_q <= mk(StAbsent, '0, 1'b0, 1'b0, '0, 16'd0, 1'b1, loads_q, writes_q);
          end else begin
            tgt_q <= hit_s_q;
            wmeta_q <= hit_m_q;
            old_rank_q <= '1;
            res_v_q <= 1'b0;
            state_q <= S_WR;
            res_q <= mk(StOk, hit_s_q, 1'b0, 1'b0, '0, hit_m_q.pins, 1'b1,
                        loads_q, writes_q);
            case (req_q.kind)
              KindUnpin: begin
                if (hit_m_q.pins != 16'd0) begin
                  wmeta_q.pins <= hit_m_q.pins - 1'b1;
                  res_q.pin_count <= hit_m_q.pins - 1'b1;
                end
              end
              KindDirty: wmeta_q.dirty <= 1'b1;
              default: begin
                if (hit_m_q.dirty && hit_m_q.pins != 16'd0) begin
                  res_q.status <= StPinned;
                end else if (hit_m_q.dirty) begin
                  wmeta_q.dirty <= 1'b0;
                  writes_q <= writes_q + 1'b1;
                  res_q <= mk(StOk, hit_s_q, 1'b0, 1'b1, hit_m_q.page, 16'd0,
                              1'b1, loads_q, writes_q + 1'b1);
                end
              end
            endcase
          end
        end
        S_WR: begin
          // Rank fix-up pass needed when a frame moves to newest.
          idx_q <= '0;
          if (req_q.kind == KindPin && old_rank_q != wmeta_q.rank &&
              (policy_q || !hit_q) && !(free_q && !hit_q)) begin
            state_q <= S_SHIFT;
          end else begin
            state_q <= S_OUT;
            res_v_q <= 1'b1;
          end
        end
        S_SHIFT: begin
          if (scan_go) begin
            pipe_v_q <= !(idx_lo == tgt_q);
            pipe_a_q <= idx_lo;
            idx_q <= idx_q + 1'b1;
          end else if (!pipe_v_q) begin
            state_q <= S_OUT;
            res_v_q <= 1'b1;
          end
        end
        S_FLUSH: begin
          // Scan all frames for the current rank, one read a cycle. The first
          // pass counts candidates over all ranks.
          if (scan_go) begin
            pipe_v_q <= 1'b1;
            pipe_a_q <= idx_lo;
            idx_q <= idx_q + 1'b1;
          end
          if (pipe_v_q && pv && rdata.dirty && rdata.pins == 16'd0) begin
            if (flpre_q) begin
              fltotal_q <= fltotal_q + 1'b1;
            end else if (rdata.rank == flrank_q) begin
              flfound_q <= 1'b1;
              tgt_q <= pipe_a_q;
              wmeta_q <= rdata;
              wmeta_q.dirty <= 1'b0;
            end
          end else if (!pipe_v_q && !scan_go) begin
            idx_q <= '0;
            if (flpre_q) begin
              flpre_q <= 1'b0;
              if (fltotal_q == '0) begin
                res_q <= mk(StOk, '0, 1'b0, 1'b0, '0, 16'd0, 1'b1, loads_q, writes_q);
                res_v_q <= 1'b1;
                after_out_q <= 1'b0;
                state_q <= S_OUT;
              end
            end else if (flfound_q) begin
              state_q <= S_FLWR;
            end else begin
              flrank_q <= flrank_q + 1'b1;
            end
          end
        end
        S_FLWR: begin
          flfound_q <= 1'b0;
          flrank_q <= flrank_q + 1'b1;
          flcnt_q <= flcnt_q + 1'b1;
          writes_q <= writes_q + 1'b1;
          res_q <= mk(StOk, tgt_q, 1'b0, 1'b1, wmeta_q.page, 16'd0,
                      (flcnt_q + 1'b1) == fltotal_q, loads_q, writes_q + 1'b1);
          res_v_q <= 1'b1;
          after_out_q <= (flcnt_q + 1'b1) != fltotal_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (res_v_q && res.ready) begin
            state_q <= after_out_q ? S_FLUSH : S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Busy blocks req; occ_q bounded; a waiting res_q holds; no write while res_v_q.
  `BPFR_ASSERT_IMP(a_no_req_busy, state_q != S_IDLE, !req.ready)
  `BPFR_ASSERT_IMP(a_occ_range, 1'b1, occ_q <= OccW'(NumFrames))
  `BPFR_ASSERT_NEXT(a_out_wait, res_v_q && !res.ready, res_v_q && $stable(res_q))
  `BPFR_ASSERT_IMP(a_wr_not_out, we, !res_v_q)
endmodule
